[hdl/sst_pkg.sv]
// Shared types and constants of the scoped symbol table.
// No dependencies; imported by sst_cell and scoped_symbol_register_table_top.
package sst_pkg;

  // Command codes carried in a command beat.
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_ENTER  = 2'd2,
    CMD_EXIT   = 2'd3
  } sst_cmd_t;

  // Status codes returned with every result beat.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } sst_status_t;

  localparam int VALUE_BITS = 32;
  localparam int KEY_PORT_BITS = 16;
  localparam logic signed [VALUE_BITS-1:0] MISS_VALUE = -32'sd1;

  // Search token that walks down the cell chain, one cell per clock.
  typedef struct packed {
    logic                         vld;
    logic                         found;
    logic signed [VALUE_BITS-1:0] value;
  } sst_tok_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic start;  // inject a token at the newest binding
    logic add;    // current search is an add: match only inside the open scope
    logic wr_en;  // append the held key and value at the newest position
  } sst_ctl_t;

endpackage

[hdl/scoped_symbol_register_table_top.sv]
// Top level of the scoped symbol table: command sequencer, cell chain, scope RAM.
// Depends on sst_pkg, sst_ram and sst_cell.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   command, key, bind_value
//   out_     output     out_valid / out_stall found, result_value, status
//
// One command is worked on at a time. For a lookup or an add the search token
// walks down the cell chain one cell per clock from the newest binding to the
// oldest, and the result is taken when the token leaves the chain. An add
// refused on a full table walks the chain like any other add. With an empty
// table, and for an enter, or an exit at the outermost level, a command goes
// straight to the result state; an accepted exit passes first through a state
// for the registered read of the scope RAM. Reset is synchronous and leaves
// the table empty at scope level 0; no clearing pass is needed. A result
// waiting in the output register does not hold up the next command beat, only
// the delivery of the following result.
module scoped_symbol_register_table_top #(
  parameter int ENTRIES    = 256,
  parameter int MAX_SCOPES = 32,
  parameter int KEY_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_key,
  input  logic signed [31:0] in_bind_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status
);
  import sst_pkg::*;

  // Keys are compared in their low KEY_BITS bits; the port carries 16.
  localparam int KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
  // The binding count must be able to hold ENTRIES itself.
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = $clog2(MAX_SCOPES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EXIT_RD,
    S_RESULT
  } state_t;

  state_t             state_r;
  sst_cmd_t           cmd_r;
  logic [KW-1:0]      key_r;
  logic signed [31:0] bv_r;
  sst_ctl_t           ctl_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      base_r;
  logic [LW-1:0]      level_r;

  logic               res_found_r;
  logic signed [31:0] res_value_r;
  sst_status_t        res_status_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic signed [31:0] out_value_r;
  logic [1:0]         out_status_r;

  logic               accept;
  logic               ram_we;
  logic [CW-1:0]      ram_rdata;

  sst_tok_t           tok_w [ENTRIES+1];

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Opening a scope records where its bindings will begin.
  assign ram_we = accept && (sst_cmd_t'(in_command) == CMD_ENTER) &&
                  (level_r != LW'(MAX_SCOPES - 1));

  // The read port always looks at the start of the enclosing scope, so the
  // value is ready in the cycle after an exit is accepted.
  sst_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_SCOPES)
  ) u_scope_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (level_r + LW'(1)),
    .wdata (count_r),
    .raddr (level_r - LW'(1)),
    .rdata (ram_rdata)
  );

  // Cell chain: cell i holds binding i; tokens travel from high to low index
  // and leave the chain at cell 0.
  assign tok_w[ENTRIES] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    sst_cell #(
      .IDX (i),
      .KW  (KW),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl_r),
      .key        (key_r),
      .bind_value (bv_r),
      .count      (count_r),
      .base       (base_r),
      .tok_in     (tok_w[i+1]),
      .tok_out    (tok_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctl_r       <= '0;
      count_r     <= '0;
      base_r      <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Start and append are single-cycle strobes.
      ctl_r.start <= 1'b0;
      ctl_r.wr_en <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r        <= sst_cmd_t'(in_command);
            key_r        <= in_key[KW-1:0];
            bv_r         <= in_bind_value;
            ctl_r.add    <= (sst_cmd_t'(in_command) == CMD_ADD);
            res_found_r  <= 1'b0;
            res_value_r  <= '0;
            res_status_r <= ST_OK;
            case (sst_cmd_t'(in_command))
              CMD_ADD: begin
                if (count_r == '0) begin
                  // Nothing to search: the new binding goes straight in.
                  ctl_r.wr_en <= 1'b1;
                  count_r     <= count_r + CW'(1);
                  state_r     <= S_RESULT;
                end else begin
                  ctl_r.start <= 1'b1;
                  state_r     <= S_SEARCH;
                end
              end
              CMD_LOOKUP: begin
                if (count_r == '0) begin
                  res_value_r <= MISS_VALUE;
                  state_r     <= S_RESULT;
                end else begin
                  ctl_r.start <= 1'b1;
                  state_r     <= S_SEARCH;
                end
              end
              CMD_ENTER: begin
                if (level_r == LW'(MAX_SCOPES - 1)) begin
                  res_status_r <= ST_OVERFLOW;
                end else begin
                  level_r <= level_r + LW'(1);
                  base_r  <= count_r;
                end
                state_r <= S_RESULT;
              end
              CMD_EXIT: begin
                if (level_r == '0) begin
                  res_status_r <= ST_UNDERFLOW;
                  state_r      <= S_RESULT;
                end else begin
                  // Dropping the scope is just a rewind of the binding count.
                  count_r <= base_r;
                  level_r <= level_r - LW'(1);
                  state_r <= S_EXIT_RD;
                end
              end
              default: begin
                state_r <= S_RESULT;
              end
            endcase
          end
        end

        S_SEARCH: begin
          if (tok_w[0].vld) begin
            if (cmd_r == CMD_LOOKUP) begin
              res_found_r <= tok_w[0].found;
              res_value_r <= tok_w[0].found ? tok_w[0].value : MISS_VALUE;
            end else if (!tok_w[0].found) begin
              // A hit was overwritten in place by its cell; a miss appends.
              if (count_r == CW'(ENTRIES)) begin
                res_status_r <= ST_FULL;
              end else begin
                ctl_r.wr_en <= 1'b1;
                count_r     <= count_r + CW'(1);
              end
            end
            state_r <= S_RESULT;
          end
        end

        S_EXIT_RD: begin
          // The outermost scope always starts at zero and has no RAM entry.
          base_r  <= (level_r == '0) ? '0 : ram_rdata;
          state_r <= S_RESULT;
        end

        S_RESULT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= res_found_r;
            out_value_r  <= res_value_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

  // The table never holds more bindings than it has cells.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("binding count exceeds table size");

  // The open scope never starts beyond the newest binding.
  assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= count_r)
    else $error("scope start beyond binding count");

  // A token leaves the chain only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[0].vld |-> (state_r == S_SEARCH))
    else $error("search token outside of a search");

  // A search is launched only into a non-empty table.
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.start |-> (count_r != '0))
    else $error("search started on an empty table");

endmodule

[hdl/sst_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sst_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/sst_cell.sv]
// One binding slot of the symbol table chain: key, value and a token stage.
// Depends on sst_pkg.
module sst_cell #(
  parameter int IDX = 0,
  parameter int KW  = 16,
  parameter int CW  = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sst_pkg::sst_ctl_t      ctl,
  input  logic [KW-1:0]          key,
  input  logic signed [31:0]     bind_value,
  input  logic [CW-1:0]          count,
  input  logic [CW-1:0]          base,
  input  sst_pkg::sst_tok_t      tok_in,
  output sst_pkg::sst_tok_t      tok_out
);
  import sst_pkg::*;

  logic [KW-1:0]         key_r;
  logic signed [31:0]    value_r;
  sst_tok_t              tok_r;
  sst_tok_t              tok_cur;
  sst_tok_t              tok_nxt;
  logic                  at_top;
  logic                  hit;

  // This cell holds the newest binding when its index is count - 1.
  assign at_top = (CW'(IDX + 1) == count);

  always_comb begin
    if (ctl.start && at_top) begin
      tok_cur = '{vld: 1'b1, found: 1'b0, value: '0};
    end else begin
      tok_cur = tok_in;
    end
    hit = tok_cur.vld && !tok_cur.found && (key_r == key) &&
          (!ctl.add || (CW'(IDX) >= base));
    tok_nxt = tok_cur;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.value = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
    if (ctl.wr_en && at_top) begin
      key_r   <= key;
      value_r <= bind_value;
    end else if (hit && ctl.add) begin
      value_r <= bind_value;
    end
  end

  assign tok_out = tok_r;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the scoped symbol table: directed rows, then random
// scope traffic checked against an in-bench model of the bindings and scope stack.
// Depends on sst_pkg and scoped_symbol_register_table_top.
module tb;
  import sst_pkg::*;

  // Sizes match the defaults of the block; the predictor relies on them.
  localparam int ENTRIES      = 256;
  localparam int MAX_SCOPES   = 32;
  localparam int ITEM_GOAL    = 1750;
  localparam int HOLD_CYCLES  = 600;
  // A search walks every live binding, so one full walk is the longest quiet time.
  localparam int DRAIN_CYCLES = ENTRIES + 8;
  localparam int REPORT_CAP   = 40;
  localparam int POOL_N       = 12;
  localparam int DIRECTED_N   = 23;

  // What one result beat carries.
  typedef struct packed {
    logic                         found;
    logic signed [VALUE_BITS-1:0] value;
    sst_status_t                  status;
  } sym_result_t;

  // One directed row. When typed is set, res is the answer written in by hand;
  // otherwise the predictor supplies it.
  typedef struct packed {
    sst_cmd_t                     cmd;
    logic [KEY_PORT_BITS-1:0]     key;
    logic signed [VALUE_BITS-1:0] value;
    logic                         typed;
    sym_result_t                  res;
  } step_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [1:0]                   in_command;
  logic [KEY_PORT_BITS-1:0]     in_key;
  logic signed [VALUE_BITS-1:0] in_bind_value;
  logic                         out_valid;
  logic                         out_stall;
  logic                         out_found;
  logic signed [VALUE_BITS-1:0] out_result_value;
  logic [1:0]                   out_status;

  // Travels with each beat, driven like the payload, so the scoreboard sees
  // the tag that belongs to the beat it accepts.
  logic        beat_typed;
  sym_result_t beat_typed_res;

  // Predictor state: a flat store of bindings and the start of each open scope.
  logic [KEY_PORT_BITS-1:0]     bind_key [ENTRIES];
  logic signed [VALUE_BITS-1:0] bind_val [ENTRIES];
  int                           live_count = 0;
  int                           open_level = 0;
  int                           scope_first [MAX_SCOPES];

  sym_result_t pending_answers [$];

  // Run statistics and bookkeeping.
  int err_n = 0;
  int results_checked = 0;
  int beats_sent = 0;
  int cmd_seen [4] = '{0, 0, 0, 0};
  int status_seen [4] = '{0, 0, 0, 0};
  int lookup_hits = 0;
  int deepest = 0;
  int most_bindings = 0;

  // The stimulus keeps its own idea of the scope level so that it never has to
  // peek at the predictor while a beat is in flight.
  int gen_level = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  logic [KEY_PORT_BITS-1:0] key_pool [POOL_N];

  // Directed rows: extremes of key and value, every command, the underflow at
  // the outermost level, shadowing by an inner scope and overwrite within one.
  step_row_t directed_steps [DIRECTED_N] = '{
    '{CMD_LOOKUP, 16'h0000, 32'sh0000_0000, 1'b1, '{1'b0, MISS_VALUE, ST_OK}},
    '{CMD_EXIT,   16'hFFFF, 32'shFFFF_FFFF, 1'b1, '{1'b0, 32'sh0, ST_UNDERFLOW}},
    '{CMD_ADD,    16'h0000, 32'sh7FFF_FFFF, 1'b1, '{1'b0, 32'sh0, ST_OK}},
    '{CMD_ADD,    16'hFFFF, 32'sh8000_0000, 1'b1, '{1'b0, 32'sh0, ST_OK}},
    '{CMD_LOOKUP, 16'hFFFF, 32'sh0000_0000, 1'b1, '{1'b1, 32'sh8000_0000, ST_OK}},
    '{CMD_LOOKUP, 16'h0000, 32'shFFFF_FFFF, 1'b1, '{1'b1, 32'sh7FFF_FFFF, ST_OK}},
    '{CMD_LOOKUP, 16'h8000, 32'sh0000_0000, 1'b1, '{1'b0, MISS_VALUE, ST_OK}},
    '{CMD_ENTER,  16'hFFFF, 32'sh7FFF_FFFF, 1'b1, '{1'b0, 32'sh0, ST_OK}},
    '{CMD_ADD,    16'hFFFF, 32'shFFFF_FFFF, 1'b0, '0},
    '{CMD_LOOKUP, 16'hFFFF, 32'sh0000_0000, 1'b0, '0},
    '{CMD_ADD,    16'hFFFF, 32'sh0000_0001, 1'b0, '0},
    '{CMD_LOOKUP, 16'hFFFF, 32'sh0000_0000, 1'b0, '0},
    '{CMD_LOOKUP, 16'h0000, 32'sh0000_0000, 1'b0, '0},
    '{CMD_ENTER,  16'h0000, 32'sh0000_0000, 1'b0, '0},
    '{CMD_ADD,    16'h0000, 32'sh0000_0000, 1'b0, '0},
    '{CMD_LOOKUP, 16'h0000, 32'sh0000_0000, 1'b0, '0},
    '{CMD_EXIT,   16'h0000, 32'sh0000_0000, 1'b0, '0},
    '{CMD_EXIT,   16'h1234, 32'sh0000_0000, 1'b0, '0},
    '{CMD_LOOKUP, 16'hFFFF, 32'sh0000_0000, 1'b0, '0},
    '{CMD_ADD,    16'h5555, 32'sh5555_5555, 1'b0, '0},
    '{CMD_LOOKUP, 16'hAAAA, 32'shAAAA_AAAA, 1'b0, '0},
    '{CMD_LOOKUP, 16'h5555, 32'sh0000_0000, 1'b0, '0},
    '{CMD_EXIT,   16'h0000, 32'sh0000_0000, 1'b1, '{1'b0, 32'sh0, ST_UNDERFLOW}}
  };

  scoped_symbol_register_table_top #(
    .ENTRIES   (ENTRIES),
    .MAX_SCOPES(MAX_SCOPES),
    .KEY_BITS  (KEY_PORT_BITS)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_bind_value   (in_bind_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_result_value(out_result_value),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the predicted table and returns the answer the
  // block should give. Adds only look inside the innermost scope; lookups scan
  // from the newest binding back, which makes inner scopes shadow outer ones.
  function automatic sym_result_t symtab_apply(input sst_cmd_t cmd,
                                               input logic [KEY_PORT_BITS-1:0] key,
                                               input logic signed [VALUE_BITS-1:0] value);
    sym_result_t r;
    int idx;
    int base;
    bit hit;
    r = '{found: 1'b0, value: '0, status: ST_OK};
    hit = 1'b0;
    base = (open_level == 0) ? 0 : scope_first[open_level];
    case (cmd)
      CMD_ADD: begin
        for (idx = base; idx < live_count && !hit; idx++) begin
          if (bind_key[idx] == key) begin
            bind_val[idx] = value;
            hit = 1'b1;
          end
        end
        // A key that is new to this scope needs a free slot.
        if (!hit && live_count >= ENTRIES) begin
          r.status = ST_FULL;
        end else if (!hit) begin
          bind_key[live_count] = key;
          bind_val[live_count] = value;
          live_count++;
        end
      end
      CMD_LOOKUP: begin
        r.value = MISS_VALUE;
        for (idx = live_count - 1; idx >= 0 && !r.found; idx--) begin
          if (bind_key[idx] == key) begin
            r.found = 1'b1;
            r.value = bind_val[idx];
          end
        end
      end
      CMD_ENTER: begin
        if (open_level + 1 >= MAX_SCOPES) begin
          r.status = ST_OVERFLOW;
        end else begin
          open_level++;
          scope_first[open_level] = live_count;
        end
      end
      default: begin
        // Leaving a scope drops every binding made since it was opened.
        if (open_level == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          live_count = base;
          open_level--;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_n < REPORT_CAP)
      $display("MISMATCH at %0t, result %0d: %s", $time, results_checked, what);
    err_n++;
  endtask

  // Scoreboard. Both checks sample at the clock edge, before the block's own
  // updates land, so the order of processes within a step does not matter.
  always @(posedge clk) begin : scoreboard
    sym_result_t want;
    sym_result_t got;
    sym_result_t answer;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result beat with no command awaiting one");
        end else begin
          want = pending_answers.pop_front();
          if (out_found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", out_found, want.found));
          if (out_result_value !== want.value)
            report_mismatch($sformatf("value %0d, expected %0d",
                                      out_result_value, want.value));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %s",
                                      out_status, want.status.name()));
        end
        results_checked++;
      end
      if (in_valid && !in_stall) begin
        got = symtab_apply(sst_cmd_t'(in_command), in_key, in_bind_value);
        answer = beat_typed ? beat_typed_res : got;
        pending_answers = {pending_answers, answer};
        cmd_seen[in_command]++;
        status_seen[got.status]++;
        if (got.found)
          lookup_hits++;
        if (open_level > deepest)
          deepest = open_level;
        if (live_count > most_bindings)
          most_bindings = live_count;
      end
    end
  end

  // Result side. It picks a stall pattern for a random stretch: none at all,
  // light or heavy random stalls, or a regular on/off pattern. When the
  // stimulus asks for it, it holds off for a long count of cycles so that the
  // block fills up and pushes back on its input.
  initial begin : receiver
    int mode;
    int span;
    int k;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 150);
        for (k = 0; k < span && !hold_req; k++) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= k[1];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Keys come mostly from a small pool, so adds overwrite and lookups hit;
  // the rest are fully random so every key bit moves.
  function automatic logic [KEY_PORT_BITS-1:0] pick_key();
    if ($urandom_range(0, 9) < 7)
      return key_pool[$urandom_range(0, POOL_N - 1)];
    return KEY_PORT_BITS'($urandom);
  endfunction

  // Sender pacing: bursts of random length, some long, with random gaps.
  // It runs right after the previous beat was taken, so lowering valid here
  // never clashes with raising it in the same step.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 24);
    end
  endtask

  // Offers one beat and returns at the edge where it is taken. Valid stays up
  // so that a following beat can go out back to back.
  task automatic send_beat(input sst_cmd_t cmd, input logic [KEY_PORT_BITS-1:0] key,
                           input logic signed [VALUE_BITS-1:0] value,
                           input logic typed = 1'b0, input sym_result_t res = '0);
    pace_sender();
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_key         <= key;
    in_bind_value  <= value;
    beat_typed     <= typed;
    beat_typed_res <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    case (cmd)
      CMD_ENTER: if (gen_level < MAX_SCOPES - 1) gen_level++;
      CMD_EXIT:  if (gen_level > 0) gen_level--;
      default: ;
    endcase
  endtask

  // Stops offering and waits until every answer is back. Only called right
  // after a beat was taken; the first wait lets the scoreboard log that beat.
  task automatic sender_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // A well-formed scope: open it, mix adds and lookups, maybe open one inside,
  // look around again after that inner scope is gone, and close it if asked.
  task automatic scope_block(input bit nested, input bit close);
    int n;
    int k;
    send_beat(CMD_ENTER, KEY_PORT_BITS'($urandom), $urandom);
    n = $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) == 0)
        send_beat(CMD_ADD, pick_key(), $urandom);
      else
        send_beat(CMD_LOOKUP, pick_key(), $urandom);
    end
    if (nested) begin
      scope_block(1'b0, 1'b1);
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++)
        send_beat(CMD_LOOKUP, pick_key(), $urandom);
    end
    if (close)
      send_beat(CMD_EXIT, KEY_PORT_BITS'($urandom), $urandom);
  endtask

  // Opens scopes up to the deepest level, tries to go two deeper, then
  // unwinds all the way and tries one exit too many.
  task automatic deep_nest();
    int k;
    while (gen_level < MAX_SCOPES - 1) begin
      send_beat(CMD_ENTER, KEY_PORT_BITS'($urandom), $urandom);
      if ($urandom_range(0, 2) == 0)
        send_beat(CMD_ADD, pick_key(), $urandom);
    end
    for (k = 0; k < 2; k++)
      send_beat(CMD_ENTER, KEY_PORT_BITS'($urandom), $urandom);
    for (k = 0; k < 4; k++)
      send_beat(CMD_LOOKUP, pick_key(), $urandom);
    while (gen_level > 0) begin
      send_beat(CMD_EXIT, KEY_PORT_BITS'($urandom), $urandom);
      if ($urandom_range(0, 3) == 0)
        send_beat(CMD_LOOKUP, pick_key(), $urandom);
    end
    send_beat(CMD_EXIT, KEY_PORT_BITS'($urandom), $urandom);
  endtask

  // Fills the store from a fresh scope with distinct keys until adds are
  // refused, checks that a key already in the scope can still be rewritten
  // while full, then closes the scope to give the space back.
  task automatic fill_scope();
    logic [KEY_PORT_BITS-1:0] first;
    int k;
    if (gen_level == MAX_SCOPES - 1)
      send_beat(CMD_EXIT, KEY_PORT_BITS'($urandom), $urandom);
    send_beat(CMD_ENTER, KEY_PORT_BITS'($urandom), $urandom);
    first = KEY_PORT_BITS'($urandom);
    for (k = 0; k < ENTRIES + 4; k++)
      send_beat(CMD_ADD, first + k[KEY_PORT_BITS-1:0], $urandom);
    send_beat(CMD_ADD, first + 16'd3, $urandom);
    for (k = 0; k < 6; k++)
      send_beat(CMD_LOOKUP, first + KEY_PORT_BITS'($urandom_range(0, ENTRIES + 8)), $urandom);
    send_beat(CMD_EXIT, KEY_PORT_BITS'($urandom), $urandom);
  endtask

  initial begin : stimulus
    int i;
    int k;
    int n;
    int choice;
    int holds_issued;
    int fills_done;
    holds_issued = 0;
    fills_done = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_LOOKUP;
    in_key         <= '0;
    in_bind_value  <= '0;
    beat_typed     <= 1'b0;
    beat_typed_res <= '0;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'h8000;
    key_pool[3] = 16'h0001;
    for (i = 4; i < POOL_N; i++)
      key_pool[i] = KEY_PORT_BITS'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the table of rows.
    for (i = 0; i < DIRECTED_N; i++)
      send_beat(directed_steps[i].cmd, directed_steps[i].key, directed_steps[i].value,
                directed_steps[i].typed, directed_steps[i].res);
    sender_pause();

    // Random part opens with one trip to the deepest scope and one fill of the
    // store, so both limits are hit whatever the seed.
    deep_nest();
    sender_pause();
    fill_scope();
    fills_done++;
    sender_pause();

    while (beats_sent < ITEM_GOAL) begin
      // Two long receiver hold-offs while the sender keeps offering beats.
      if ((holds_issued == 0 && beats_sent >= 300) ||
          (holds_issued == 1 && beats_sent >= 1100)) begin
        hold_req = 1'b1;
        holds_issued++;
      end
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
        scope_block($urandom_range(0, 2) == 0, 1'b1);
      end else if (choice < 63) begin
        n = $urandom_range(2, 10);
        for (k = 0; k < n; k++)
          send_beat(CMD_LOOKUP, pick_key(), $urandom);
      end else if (choice < 75) begin
        // Noise: any command with any fields.
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          send_beat(sst_cmd_t'($urandom_range(0, 3)), KEY_PORT_BITS'($urandom), $urandom);
      end else if (choice < 82) begin
        // Broken sequence: a scope that is never closed.
        scope_block(1'b0, 1'b0);
      end else if (choice < 88) begin
        // Broken sequence: a stray exit, which underflows at the outer level.
        send_beat(CMD_EXIT, KEY_PORT_BITS'($urandom), $urandom);
      end else if (choice < 92) begin
        deep_nest();
        sender_pause();
      end else if (choice < 93 && fills_done < 2) begin
        fill_scope();
        fills_done++;
        sender_pause();
      end else if (choice < 96) begin
        send_beat(CMD_LOOKUP, pick_key(), $urandom);
        sender_pause();
      end else begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++)
          send_beat(CMD_ADD, pick_key(), $urandom);
      end
    end

    // Drain, then give the block one full search time to show any stray beat.
    sender_pause();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: ran %0d commands (add %0d, lookup %0d with %0d hits, enter %0d, exit %0d)",
             beats_sent, cmd_seen[CMD_ADD], cmd_seen[CMD_LOOKUP], lookup_hits,
             cmd_seen[CMD_ENTER], cmd_seen[CMD_EXIT]);
    $display("tb: %0d results checked; full %0d, overflow %0d, underflow %0d; %0d deep, %0d bound",
             results_checked, status_seen[ST_FULL], status_seen[ST_OVERFLOW],
             status_seen[ST_UNDERFLOW], deepest, most_bindings);
    if (err_n == 0 && pending_answers.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, where every command walks a
  // full store and waits out every stall and gap.
  initial begin : watchdog
    #30_000_000;
    $display("tb: timed out with %0d answers outstanding", pending_answers.size());
    $display("tb: errors");
    $finish;
  end

endmodule

[sim.f]
hdl/sst_pkg.sv
hdl/sst_ram.sv
hdl/sst_cell.sv
hdl/scoped_symbol_register_table_top.sv
tb/sv/tb.sv
